FILE: sv/awm_pkg.sv
package awm_pkg;

    localparam int CMD_W    = 2;
    localparam int LETTER_W = 5;
    localparam int POS_W    = 32;

    localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PATTERN = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TEXT    = 2'd2;

    // Result queue sizing.
    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = 2;
    localparam int RES_LVL_W = 3;

    typedef enum logic [1:0] {
        OP_PATTERN,
        OP_TEXT,
        OP_CLEAR
    } t_op;

endpackage

FILE: sv/anagram_window_matcher.sv
// Channel   Valid     Ready     Payload
// input     i_valid   o_ready   i_command, i_letter
// result    o_valid   i_ready   o_match_start
//
// One item per cycle while o_ready is high. A result for the text letter that
// completes the match goes through history read, tally read, update, result queue.
// o_ready drops only when the four-entry result queue plus items in flight
// would overflow, that is when results are not taken.
// Reset is synchronous; the tally tables clear at once.
module anagram_window_matcher #(
    parameter int MAX_PATTERN_LEN = 64,
    parameter int ALPHABET_SIZE   = 26
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [awm_pkg::CMD_W-1:0]      i_command,
    input  logic [awm_pkg::LETTER_W-1:0]   i_letter,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [awm_pkg::POS_W-1:0]      o_match_start
);

    localparam int HW  = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;
    localparam int PLW = $clog2(MAX_PATTERN_LEN + 1);
    localparam int CW  = PLW + 1;
    localparam int AW  = $clog2(ALPHABET_SIZE);
    localparam int DW  = $clog2(MAX_PATTERN_LEN) + 2;
    localparam int NZW = $clog2(ALPHABET_SIZE + 1);
    localparam int OCW = awm_pkg::RES_LVL_W + 1;

    typedef struct packed {
        awm_pkg::t_op              op;
        logic [AW-1:0]             letter;
        logic                      remove;
        logic [awm_pkg::POS_W-1:0] pos;
        logic [PLW-1:0]            plen;
    } t_stage;

    // Front end.
    logic [PLW-1:0]            r_pattern_len, n_pattern_len;
    logic [awm_pkg::POS_W-1:0] r_text_pos, n_text_pos;
    logic [HW-1:0]             r_hist_wr, n_hist_wr;
    logic [PLW-1:0]            r_win_fill, n_win_fill;
    logic                      r_text_begun, n_text_begun;

    logic          acc;
    logic          letter_ok;
    logic          is_clear;
    logic          is_pat;
    logic          is_text;
    logic          text_win;
    logic [CW-1:0] old_sum;
    logic [HW-1:0] old_idx;
    logic [HW-1:0] hist_wr_inc;
    logic [awm_pkg::LETTER_W-1:0] hist_q;

    // Pipeline.
    logic   r_s1_vld, n_s1_vld;
    t_stage r_s1, n_s1;
    logic   r_s2_vld;
    t_stage r_s2;
    logic [AW-1:0] r_s2_old;

    // Tally tables: A counts pattern letters and letters leaving the window,
    // B counts letters entering it; the difference is A minus B.
    logic [DW-1:0] an, ao, bn, bo;
    logic          a_we, b_we;
    logic [AW-1:0] a_waddr;
    logic [DW-1:0] a_wdata, b_wdata;
    logic          tally_clear;

    logic [DW-1:0] d_n, d_o, d_n_inc, d_n_dec, d_o_inc;
    logic          up_n, dn_n, up_o, dn_o;
    logic          same_letter;

    logic [NZW-1:0] r_nonzero, n_nonzero;
    logic [PLW-1:0] r_since, n_since;
    logic [PLW-1:0] since_inc;
    logic           match;
    logic           push;
    logic [awm_pkg::POS_W-1:0] start_pos;

    logic [awm_pkg::RES_LVL_W-1:0] res_level;
    logic [OCW-1:0]                occupancy;

    assign occupancy = OCW'(res_level) + OCW'(r_s1_vld) + OCW'(r_s2_vld);
    assign o_ready   = occupancy < OCW'(awm_pkg::RES_DEPTH);
    assign acc       = i_valid && o_ready;

    assign letter_ok = 32'(i_letter) < 32'(ALPHABET_SIZE);
    assign is_clear  = i_command == awm_pkg::CMD_CLEAR;
    assign is_pat    = i_command == awm_pkg::CMD_PATTERN && letter_ok && !r_text_begun &&
                       r_pattern_len < PLW'(MAX_PATTERN_LEN);
    assign is_text   = i_command == awm_pkg::CMD_TEXT && letter_ok;
    assign text_win  = is_text && r_pattern_len != '0;

    // Position of the letter that leaves the window, modulo the history depth.
    assign old_sum = CW'(r_hist_wr) + CW'(MAX_PATTERN_LEN) - CW'(r_pattern_len);
    assign old_idx = (old_sum >= CW'(MAX_PATTERN_LEN)) ?
                     HW'(old_sum - CW'(MAX_PATTERN_LEN)) : HW'(old_sum);
    assign hist_wr_inc = (r_hist_wr == HW'(MAX_PATTERN_LEN - 1)) ? '0 : r_hist_wr + 1'b1;

    always_comb begin
        n_pattern_len = r_pattern_len;
        n_text_pos    = r_text_pos;
        n_hist_wr     = r_hist_wr;
        n_win_fill    = r_win_fill;
        n_text_begun  = r_text_begun;
        if (acc) begin
            if (is_clear) begin
                n_pattern_len = '0;
                n_text_pos    = '0;
                n_hist_wr     = '0;
                n_win_fill    = '0;
                n_text_begun  = 1'b0;
            end else if (is_pat) begin
                n_pattern_len = r_pattern_len + 1'b1;
            end else if (is_text) begin
                n_text_begun = 1'b1;
                n_text_pos   = r_text_pos + 1'b1;
                if (text_win) begin
                    n_hist_wr = hist_wr_inc;
                    if (r_win_fill < PLW'(MAX_PATTERN_LEN)) begin
                        n_win_fill = r_win_fill + 1'b1;
                    end
                end
            end
        end
    end

    always_comb begin
        n_s1_vld      = acc && (is_clear || is_pat || text_win);
        n_s1.op       = is_clear ? awm_pkg::OP_CLEAR :
                        (is_pat ? awm_pkg::OP_PATTERN : awm_pkg::OP_TEXT);
        n_s1.letter   = AW'(i_letter);
        n_s1.remove   = r_win_fill >= r_pattern_len;
        n_s1.pos      = r_text_pos;
        n_s1.plen     = r_pattern_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_len <= '0;
            r_text_pos    <= '0;
            r_hist_wr     <= '0;
            r_win_fill    <= '0;
            r_text_begun  <= 1'b0;
            r_s1_vld      <= 1'b0;
            r_s2_vld      <= 1'b0;
            r_nonzero     <= '0;
            r_since       <= '0;
        end else begin
            r_pattern_len <= n_pattern_len;
            r_text_pos    <= n_text_pos;
            r_hist_wr     <= n_hist_wr;
            r_win_fill    <= n_win_fill;
            r_text_begun  <= n_text_begun;
            r_s1_vld      <= n_s1_vld;
            r_s2_vld      <= r_s1_vld;
            r_nonzero     <= n_nonzero;
            r_since       <= n_since;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1     <= n_s1;
        r_s2     <= r_s1;
        r_s2_old <= AW'(hist_q);
    end

    awm_hist_ram #(
        .DEPTH (MAX_PATTERN_LEN),
        .AW    (HW),
        .DW    (awm_pkg::LETTER_W)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (acc && text_win),
        .i_waddr (r_hist_wr),
        .i_wdata (i_letter),
        .i_raddr (old_idx),
        .o_rdata (hist_q)
    );

    assign tally_clear = r_s2_vld && r_s2.op == awm_pkg::OP_CLEAR;

    awm_tally_ram #(
        .DEPTH (ALPHABET_SIZE),
        .AW    (AW),
        .DW    (DW)
    ) u_tally_a (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (tally_clear),
        .i_we     (a_we),
        .i_waddr  (a_waddr),
        .i_wdata  (a_wdata),
        .i_raddr0 (r_s1.letter),
        .i_raddr1 (AW'(hist_q)),
        .o_rdata0 (an),
        .o_rdata1 (ao)
    );

    awm_tally_ram #(
        .DEPTH (ALPHABET_SIZE),
        .AW    (AW),
        .DW    (DW)
    ) u_tally_b (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (tally_clear),
        .i_we     (b_we),
        .i_waddr  (r_s2.letter),
        .i_wdata  (b_wdata),
        .i_raddr0 (r_s1.letter),
        .i_raddr1 (AW'(hist_q)),
        .o_rdata0 (bn),
        .o_rdata1 (bo)
    );

    assign d_n     = an - bn;
    assign d_o     = ao - bo;
    assign d_n_inc = d_n + DW'(1);
    assign d_n_dec = d_n - DW'(1);
    assign d_o_inc = d_o + DW'(1);
    assign b_wdata = bn + DW'(1);
    assign same_letter = r_s2.remove && r_s2_old == r_s2.letter;

    always_comb begin
        a_we    = 1'b0;
        b_we    = 1'b0;
        a_waddr = r_s2.letter;
        a_wdata = an + DW'(1);
        up_n    = 1'b0;
        dn_n    = 1'b0;
        up_o    = 1'b0;
        dn_o    = 1'b0;
        if (r_s2_vld) begin
            case (r_s2.op)
                awm_pkg::OP_PATTERN: begin
                    a_we = 1'b1;
                    up_n = d_n == '0;
                    dn_n = d_n_inc == '0;
                end
                awm_pkg::OP_TEXT: begin
                    b_we = 1'b1;
                    if (r_s2.remove) begin
                        a_we    = 1'b1;
                        a_waddr = r_s2_old;
                        a_wdata = ao + DW'(1);
                    end
                    // A letter that leaves and enters at once changes nothing.
                    if (!same_letter) begin
                        up_n = d_n == '0;
                        dn_n = d_n_dec == '0;
                        if (r_s2.remove) begin
                            up_o = d_o == '0;
                            dn_o = d_o_inc == '0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign since_inc = (r_since < PLW'(MAX_PATTERN_LEN)) ? r_since + 1'b1 : r_since;
    assign start_pos = r_s2.pos - (awm_pkg::POS_W'(r_s2.plen) - awm_pkg::POS_W'(1));

    always_comb begin
        n_nonzero = r_nonzero + NZW'(up_n) + NZW'(up_o) - NZW'(dn_n) - NZW'(dn_o);
        n_since   = r_since;
        match     = 1'b0;
        if (tally_clear) begin
            n_nonzero = '0;
            n_since   = '0;
        end else if (r_s2_vld && r_s2.op == awm_pkg::OP_TEXT) begin
            match   = since_inc >= r_s2.plen && n_nonzero == '0;
            n_since = match ? '0 : since_inc;
        end
    end

    assign push = match;

    awm_result_fifo u_results (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (start_pos),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_match_start),
        .o_level (res_level)
    );

    a_nonzero_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nonzero <= NZW'(ALPHABET_SIZE))
        else $error("nonzero letter count out of range");

    a_plen_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pattern_len <= PLW'(MAX_PATTERN_LEN))
        else $error("pattern length out of range");

    a_clear_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && is_clear |=> r_pattern_len == '0 && r_text_pos == '0 && !r_text_begun)
        else $error("clear did not reset the front end");

    a_clear_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tally_clear |=> r_nonzero == '0 && r_since == '0)
        else $error("clear did not reset the match state");

endmodule

FILE: sv/awm_hist_ram.sv
module awm_hist_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 5
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];

    // A read of the entry being written returns its previous contents.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

FILE: sv/awm_tally_ram.sv
module awm_tally_ram #(
    parameter int DEPTH = 26,
    parameter int AW    = 5,
    parameter int DW    = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_clear,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr0,
    input  logic [AW-1:0] i_raddr1,
    output logic [DW-1:0] o_rdata0,
    output logic [DW-1:0] o_rdata1
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_q0;
    logic [DW-1:0] r_q1;
    logic [AW-1:0] r_raddr0;
    logic [AW-1:0] r_raddr1;
    logic          r_valid [DEPTH];
    logic          r_fwd_en;
    logic [AW-1:0] r_fwd_addr;
    logic [DW-1:0] r_fwd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q0       <= r_mem[i_raddr0];
        r_q1       <= r_mem[i_raddr1];
        r_raddr0   <= i_raddr0;
        r_raddr1   <= i_raddr1;
        r_fwd_addr <= i_waddr;
        r_fwd_data <= i_wdata;
    end

    // Entries that were not written since the last clear read as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_valid[i] <= 1'b0;
            end
            r_fwd_en <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            r_fwd_en <= i_we;
        end
    end

    // The write of the cycle in which the read was issued is not yet in the
    // registered read data, so it is forwarded here.
    assign o_rdata0 = (r_fwd_en && r_fwd_addr == r_raddr0) ? r_fwd_data :
                      (r_valid[r_raddr0] ? r_q0 : '0);
    assign o_rdata1 = (r_fwd_en && r_fwd_addr == r_raddr1) ? r_fwd_data :
                      (r_valid[r_raddr1] ? r_q1 : '0);

endmodule

FILE: sv/awm_result_fifo.sv
module awm_result_fifo (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_push,
    input  logic [awm_pkg::POS_W-1:0]         i_data,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [awm_pkg::POS_W-1:0]         o_data,
    output logic [awm_pkg::RES_LVL_W-1:0]     o_level
);

    logic [awm_pkg::POS_W-1:0]     r_mem [awm_pkg::RES_DEPTH];
    logic [awm_pkg::RES_PTR_W-1:0] r_wr;
    logic [awm_pkg::RES_PTR_W-1:0] r_rd;
    logic [awm_pkg::RES_LVL_W-1:0] r_count;
    logic                          pop;

    assign pop     = o_valid && i_ready;
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd];
    assign o_level = r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= r_count + awm_pkg::RES_LVL_W'(i_push) - awm_pkg::RES_LVL_W'(pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count < awm_pkg::RES_LVL_W'(awm_pkg::RES_DEPTH)) || pop)
        else $error("result queue overflow");

endmodule
